// ===== sv/cssq_pkg.sv =====
`default_nettype none
package cssq_pkg;

   localparam int unsigned CoordW  = 32;
   localparam int unsigned CfgW    = 31;
   localparam int unsigned HalfW   = CfgW - 1;
   localparam int unsigned SqW     = 64;
   localparam int unsigned RootW   = 32;
   localparam int unsigned SqSteps = RootW;
   localparam int unsigned QuoW    = CfgW;
   localparam int unsigned ProdW   = CoordW + CfgW;
   localparam int unsigned R2W     = 2 * CfgW;
   localparam int unsigned CsrIdxW = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SHAPE  = 3'd0,
      CSR_RADIUS = 3'd1,
      CSR_SIZE_X = 3'd2,
      CSR_SIZE_Y = 3'd3,
      CSR_SIZE_Z = 3'd4
   } csr_index_type;

   // Everything an item carries alongside the root and the quotients.
   typedef struct packed {
      logic                     is_box;
      logic                     sph_inside;
      logic                     sph_outside;
      logic [2:0]               neg;
      logic [2:0][ProdW-1:0]    prod;
      logic [2:0][CoordW-1:0]   vec;
      logic [2:0][CoordW-1:0]   box_sup;
      logic [2:0][CoordW-1:0]   box_prj;
      logic                     box_inside;
   } side_type;

endpackage
`default_nettype wire

// ===== sv/cssq_sqrt_pipe.sv =====
`default_nettype none
module cssq_sqrt_pipe (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic [cssq_pkg::SqW-1:0]  in_sum,
   input  wire cssq_pkg::side_type        in_side,
   output logic                           out_valid,
   output logic [cssq_pkg::RootW-1:0]     out_root,
   output cssq_pkg::side_type             out_side
);
   import cssq_pkg::*;

   logic                vld_ff  [0:SqSteps];
   logic [SqW-1:0]      rem_ff  [0:SqSteps];
   logic [SqW-1:0]      res_ff  [0:SqSteps];
   side_type            side_ff [0:SqSteps];

   // load the radicand
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0]  <= in_sum;
      res_ff[0]  <= '0;
      side_ff[0] <= in_side;
   end

   // one result bit per stage, walking the bit pair down from the top
   for (genvar k = 0; k < SqSteps; k++) begin : g_step
      localparam int unsigned Sh = SqW - 2 - 2 * k;
      logic [SqW-1:0] bit_w;
      logic [SqW-1:0] trial_w;
      logic [SqW-1:0] rem_in;
      logic [SqW-1:0] res_in;

      always_comb begin
         bit_w   = SqW'(1) << Sh;
         trial_w = res_ff[k] + bit_w;
         if (rem_ff[k] >= trial_w) begin
            rem_in = rem_ff[k] - trial_w;
            res_in = (res_ff[k] >> 1) + bit_w;
         end else begin
            rem_in = rem_ff[k];
            res_in = res_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         rem_ff[k+1]  <= rem_in;
         res_ff[k+1]  <= res_in;
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid = vld_ff[SqSteps];
   assign out_root  = res_ff[SqSteps][RootW-1:0];
   assign out_side  = side_ff[SqSteps];

endmodule
`default_nettype wire

// ===== sv/cssq_div_pipe.sv =====
`default_nettype none
module cssq_div_pipe (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [cssq_pkg::RootW-1:0] in_root,
   input  wire cssq_pkg::side_type         in_side,
   output logic                            out_valid,
   output logic [cssq_pkg::RootW-1:0]      out_root,
   output logic [2:0][cssq_pkg::QuoW-1:0]  out_quo,
   output cssq_pkg::side_type              out_side
);
   import cssq_pkg::*;

   logic                    vld_ff  [0:QuoW];
   logic [RootW-1:0]        root_ff [0:QuoW];
   logic [2:0][ProdW-1:0]   rem_ff  [0:QuoW];
   logic [2:0][QuoW-1:0]    quo_ff  [0:QuoW];
   side_type                side_ff [0:QuoW];

   // load the three dividends |v|*radius
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      root_ff[0] <= in_root;
      rem_ff[0]  <= in_side.prod;
      quo_ff[0]  <= '0;
      side_ff[0] <= in_side;
   end

   // restoring division, one quotient bit per stage for each axis
   for (genvar j = 0; j < QuoW; j++) begin : g_step
      localparam int unsigned Sh = QuoW - 1 - j;
      logic [ProdW-1:0]        dvs_w;
      logic [2:0][ProdW-1:0]   rem_in;
      logic [2:0][QuoW-1:0]    quo_in;

      always_comb begin
         dvs_w = ProdW'(root_ff[j]) << Sh;
         for (int a = 0; a < 3; a++) begin
            if (rem_ff[j][a] >= dvs_w) begin
               rem_in[a] = rem_ff[j][a] - dvs_w;
               quo_in[a] = {quo_ff[j][a][QuoW-2:0], 1'b1};
            end else begin
               rem_in[a] = rem_ff[j][a];
               quo_in[a] = {quo_ff[j][a][QuoW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else begin
            vld_ff[j+1] <= vld_ff[j];
         end
         root_ff[j+1] <= root_ff[j];
         rem_ff[j+1]  <= rem_in;
         quo_ff[j+1]  <= quo_in;
         side_ff[j+1] <= side_ff[j];
      end
   end

   assign out_valid = vld_ff[QuoW];
   assign out_root  = root_ff[QuoW];
   assign out_quo   = quo_ff[QuoW];
   assign out_side  = side_ff[QuoW];

endmodule
`default_nettype wire

// ===== sv/convex_shape_support_query_unit.sv =====
`default_nettype none
// Channel    | ports                                  | handshake
// -----------+----------------------------------------+------------------------------
// request    | start, busy, req_vec_x/y/z             | taken when start & !busy
// response   | rsp_valid, rsp_support_*, rsp_inside_res, rsp_proj_* | one-cycle strobe
// csr        | csr_we, csr_index, csr_wdata           | written when csr_we is high
//
// A word is accepted in every cycle; busy is held low, since nothing downstream
// can push back. The pipe holds the input and square/product stages, 33 in the
// square-root pipe, 32 in the divider, then the output register. The root and the
// three divisions, one bit per stage, set that depth.
// Synchronous reset clears the valid bits and restores the register defaults.
module convex_shape_support_query_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [31:0]            req_vec_x,
   input  wire logic signed [31:0]            req_vec_y,
   input  wire logic signed [31:0]            req_vec_z,
   output logic                               rsp_valid,
   output logic signed [31:0]                 rsp_support_x,
   output logic signed [31:0]                 rsp_support_y,
   output logic signed [31:0]                 rsp_support_z,
   output logic                               rsp_inside_res,
   output logic signed [31:0]                 rsp_proj_x,
   output logic signed [31:0]                 rsp_proj_y,
   output logic signed [31:0]                 rsp_proj_z,
   input  wire logic                          csr_we,
   input  wire logic [cssq_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [cssq_pkg::CfgW-1:0]     csr_wdata
);
   import cssq_pkg::*;

   // configuration registers
   logic                     shape_ff;
   logic [CfgW-1:0]          radius_ff;
   logic [2:0][CfgW-1:0]     size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff   <= 1'b0;
         radius_ff  <= CfgW'(65536);
         size_ff[0] <= CfgW'(131072);
         size_ff[1] <= CfgW'(131072);
         size_ff[2] <= CfgW'(131072);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHAPE:  shape_ff   <= csr_wdata[0];
            CSR_RADIUS: radius_ff  <= csr_wdata;
            CSR_SIZE_X: size_ff[0] <= csr_wdata;
            CSR_SIZE_Y: size_ff[1] <= csr_wdata;
            CSR_SIZE_Z: size_ff[2] <= csr_wdata;
            default: ;  // drop writes beyond the list
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 0: capture the word
   logic                       s0_vld_ff;
   logic [2:0][CoordW-1:0]     s0_vec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start & ~busy;
      end
      s0_vec_ff[0] <= req_vec_x;
      s0_vec_ff[1] <= req_vec_y;
      s0_vec_ff[2] <= req_vec_z;
   end

   // stage 1: magnitudes, squares, |v|*radius, radius^2 and the whole box answer
   logic [2:0][CoordW-1:0]   mag_w;
   logic [2:0][SqW-1:0]      sq_w;
   side_type                 side1_w;
   logic [HalfW-1:0]         half_w [0:2];
   logic signed [CoordW:0]   vs_w;
   logic signed [CoordW:0]   hs_w;

   always_comb begin
      side1_w             = '0;
      side1_w.is_box      = shape_ff;
      side1_w.box_inside  = 1'b1;
      for (int a = 0; a < 3; a++) begin
         side1_w.neg[a] = s0_vec_ff[a][CoordW-1];
         mag_w[a]       = side1_w.neg[a] ? (~s0_vec_ff[a] + CoordW'(1)) : s0_vec_ff[a];
         sq_w[a]        = SqW'(mag_w[a]) * SqW'(mag_w[a]);
         side1_w.prod[a] = ProdW'(mag_w[a]) * ProdW'(radius_ff);
         side1_w.vec[a]  = s0_vec_ff[a];

         half_w[a] = size_ff[a][CfgW-1:1];
         vs_w      = {s0_vec_ff[a][CoordW-1], s0_vec_ff[a]};
         hs_w      = (CoordW+1)'(half_w[a]);
         // minus side for zero components
         side1_w.box_sup[a] = (vs_w > 0) ? hs_w[CoordW-1:0] : -hs_w[CoordW-1:0];
         if (!(mag_w[a] < CoordW'(half_w[a]))) begin
            side1_w.box_inside = 1'b0;
         end
         if (vs_w < -hs_w) begin
            side1_w.box_prj[a] = -hs_w[CoordW-1:0];
         end else if (vs_w > hs_w) begin
            side1_w.box_prj[a] = hs_w[CoordW-1:0];
         end else begin
            side1_w.box_prj[a] = s0_vec_ff[a];
         end
      end
   end

   logic                   s1_vld_ff;
   logic [2:0][SqW-1:0]    s1_sq_ff;
   logic [R2W-1:0]         s1_r2_ff;
   side_type               s1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
      s1_sq_ff   <= sq_w;
      s1_r2_ff   <= R2W'(radius_ff) * R2W'(radius_ff);
      s1_side_ff <= side1_w;
   end

   // sum of squares and the sphere compares, straight into the root pipe
   logic [SqW-1:0]  sum_w;
   side_type        side2_w;

   always_comb begin
      sum_w               = s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];
      side2_w             = s1_side_ff;
      side2_w.sph_inside  = sum_w < SqW'(s1_r2_ff);
      side2_w.sph_outside = sum_w > SqW'(s1_r2_ff);
   end

   logic               sq_vld;
   logic [RootW-1:0]   sq_root;
   side_type           sq_side;

   cssq_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff),
      .in_sum    (sum_w),
      .in_side   (side2_w),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   logic                   dv_vld;
   logic [RootW-1:0]       dv_root;
   logic [2:0][QuoW-1:0]   dv_quo;
   side_type               dv_side;

   cssq_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_vld),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_vld),
      .out_root  (dv_root),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // output stage: sign the quotients and pick sphere or box
   logic [2:0][CoordW-1:0] sup_in;
   logic [2:0][CoordW-1:0] prj_in;
   logic                   inside_in;
   logic [CoordW-1:0]      sq_w_s;

   always_comb begin
      inside_in = dv_side.is_box ? dv_side.box_inside : dv_side.sph_inside;
      for (int a = 0; a < 3; a++) begin
         sq_w_s = dv_side.neg[a] ? -CoordW'(dv_quo[a]) : CoordW'(dv_quo[a]);
         if (dv_side.is_box) begin
            sup_in[a] = dv_side.box_sup[a];
            prj_in[a] = dv_side.box_prj[a];
         end else begin
            // zero direction gives a zero support point
            sup_in[a] = (dv_root == '0) ? '0 : sq_w_s;
            prj_in[a] = dv_side.sph_outside ? sq_w_s : dv_side.vec[a];
         end
      end
   end

   logic                    out_vld_ff;
   logic [2:0][CoordW-1:0]  sup_ff;
   logic [2:0][CoordW-1:0]  prj_ff;
   logic                    inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dv_vld;
      end
      sup_ff    <= sup_in;
      prj_ff    <= prj_in;
      inside_ff <= inside_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_support_x  = sup_ff[0];
   assign rsp_support_y  = sup_ff[1];
   assign rsp_support_z  = sup_ff[2];
   assign rsp_inside_res = inside_ff;
   assign rsp_proj_x     = prj_ff[0];
   assign rsp_proj_y     = prj_ff[1];
   assign rsp_proj_z     = prj_ff[2];

endmodule
`default_nettype wire

// ===== sim/convex_shape_support_query_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module convex_shape_support_query_unit_tb;
   import cssq_pkg::*;

   localparam int PIPE_LATENCY = 68;
   localparam int CYCLE_LIMIT  = 400000;

   // One result word as the unit should present it.
   typedef struct {
      logic signed [31:0] sup_x, sup_y, sup_z;
      logic               inside_flag;
      logic signed [31:0] prj_x, prj_y, prj_z;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_support_x, rsp_support_y, rsp_support_z;
   logic rsp_inside_res;
   logic signed [31:0] rsp_proj_x, rsp_proj_y, rsp_proj_z;
   logic csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CfgW-1:0] csr_wdata = '0;

   // Shadow copy of the shape registers, kept in step with every CSR write.
   logic        shadow_box;
   logic [30:0] shadow_radius;
   logic [30:0] shadow_size [3];

   answer_type answers_due[$];
   int      error_count = 0;
   int      cycle_count = 0;
   bit      allow_idle  = 1'b1;

   always #1 clock = ~clock;

   convex_shape_support_query_unit u_dut (.*);

   // Bail out if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Floor square root of a 64-bit sum, digit by digit.
   function automatic logic [63:0] floor_root(input logic [63:0] s);
      logic [63:0] rem, res, bit_w;
      rem = s;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > rem) bit_w >>= 2;
      while (bit_w != 0) begin
         if (rem >= res + bit_w) begin
            rem -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   // sign(a) * floor(|a| * r / n)
   function automatic logic signed [31:0] scale_axis(input logic signed [31:0] a,
                                                     input logic [30:0] r,
                                                     input logic [63:0] n);
      logic [63:0] m, q;
      m = a < 0 ? 64'(-65'(a)) : 64'(a);
      q = (m * 64'(r)) / n;
      return a < 0 ? -32'(q) : 32'(q);
   endfunction

   function automatic answer_type shape_answer(input logic signed [31:0] v [3]);
      answer_type ans;
      logic signed [31:0] sup [3], prj [3];
      logic [63:0] sum_sq, root, r_sq, m;
      logic signed [32:0] half;
      ans.inside_flag = 1'b1;
      if (!shadow_box) begin
         sum_sq = 0;
         for (int i = 0; i < 3; i++) begin
            m = v[i] < 0 ? 64'(-65'(v[i])) : 64'(v[i]);
            sum_sq += m * m;
         end
         root = floor_root(sum_sq);
         r_sq = 64'(shadow_radius) * 64'(shadow_radius);
         ans.inside_flag = sum_sq < r_sq;
         for (int i = 0; i < 3; i++) begin
            sup[i] = root == 0 ? 32'sd0 : scale_axis(v[i], shadow_radius, root);
            prj[i] = sum_sq > r_sq ? scale_axis(v[i], shadow_radius, root) : v[i];
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            half = 33'(shadow_size[i] >> 1);
            sup[i] = v[i] > 0 ? 32'(half) : 32'(-half);
            if (!((v[i] < 0 ? -33'(v[i]) : 33'(v[i])) < half)) ans.inside_flag = 1'b0;
            prj[i] = v[i];
            if (33'(v[i]) < -half) prj[i] = 32'(-half);
            if (33'(v[i]) > half)  prj[i] = 32'(half);
         end
      end
      ans.sup_x = sup[0]; ans.sup_y = sup[1]; ans.sup_z = sup[2];
      ans.prj_x = prj[0]; ans.prj_y = prj[1]; ans.prj_z = prj[2];
      return ans;
   endfunction

   // Compare each strobed word with the oldest answer due.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            $display("[%0t] result word with none due", $realtime);
            error_count++;
         end else begin
            want = answers_due.pop_front();
            if (rsp_support_x !== want.sup_x) report_mismatch("support_x", rsp_support_x, want.sup_x);
            if (rsp_support_y !== want.sup_y) report_mismatch("support_y", rsp_support_y, want.sup_y);
            if (rsp_support_z !== want.sup_z) report_mismatch("support_z", rsp_support_z, want.sup_z);
            if (rsp_inside_res !== want.inside_flag)
               report_mismatch("inside_res", 32'(rsp_inside_res), 32'(want.inside_flag));
            if (rsp_proj_x !== want.prj_x) report_mismatch("proj_x", rsp_proj_x, want.prj_x);
            if (rsp_proj_y !== want.prj_y) report_mismatch("proj_y", rsp_proj_y, want.prj_y);
            if (rsp_proj_z !== want.prj_z) report_mismatch("proj_z", rsp_proj_z, want.prj_z);
         end
      end
   end

   // Send one query word; hold start until the unit takes it.
   task automatic send_query(input logic signed [31:0] x, y, z);
      logic signed [31:0] v [3];
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      v = '{x, y, z};
      start     <= 1'b1;
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      do @(posedge clock); while (busy);
      answers_due.push_back(shape_answer(v));
   endtask

   // Drop start and wait until every answer has come back, plus the pipe depth.
   task automatic drain_pipe();
      start <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CfgW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SHAPE:  shadow_box       = value[0];
         CSR_RADIUS: shadow_radius    = value;
         CSR_SIZE_X: shadow_size[0]   = value;
         CSR_SIZE_Y: shadow_size[1]   = value;
         CSR_SIZE_Z: shadow_size[2]   = value;
         default: ;
      endcase
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed($urandom_range(0, 262143)) - 32'sd131072;
         2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         3: return $signed($urandom_range(0, 4)) - 32'sd2;
         default: return $signed($urandom_range(0, 33554431)) - 32'sd16777216;
      endcase
   endfunction

   // Directed corners on the sphere: zero direction, extremes, surface, inside.
   task automatic test_sphere_corners();
      write_csr(CSR_SHAPE, 0);
      write_csr(CSR_RADIUS, 31'd65536);
      send_query(0, 0, 0);
      send_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      send_query(32'sh80000000, 32'sh80000000, 32'sh80000000);
      send_query(32'sd65536, 0, 0);
      send_query(0, -32'sd65535, 0);
      send_query(0, 0, 32'sd65537);
      send_query(32'sd1, -32'sd1, 32'sd1);
      send_query(-32'sd300000, 32'sd5, 32'sh80000000);
      drain_pipe();
      write_csr(CSR_RADIUS, 31'h7fffffff);
      send_query(32'sh80000000, 32'sh7fffffff, -32'sd1);
      send_query(32'sd12345, 32'sd0, -32'sd9);
      drain_pipe();
      write_csr(CSR_RADIUS, 31'd0);
      send_query(0, 0, 0);
      send_query(32'sd7, -32'sd3, 0);
      drain_pipe();
   endtask

   // Directed corners on the box: zero components, faces, degenerate sizes.
   task automatic test_box_corners();
      write_csr(CSR_SHAPE, 1);
      write_csr(CSR_SIZE_X, 31'd131072);
      write_csr(CSR_SIZE_Y, 31'd3);
      write_csr(CSR_SIZE_Z, 31'h7fffffff);
      send_query(0, 0, 0);
      send_query(32'sd65536, 32'sd1, -32'sd1);
      send_query(-32'sd65535, -32'sd2, 32'sh3fffffff);
      send_query(32'sh7fffffff, 32'sh80000000, 32'sh80000000);
      send_query(32'sd65535, 32'sd0, 32'sh3ffffffe);
      drain_pipe();
      write_csr(CSR_SIZE_X, 31'd0);
      write_csr(CSR_SIZE_Y, 31'd1);
      send_query(0, 32'sd1, -32'sd5);
      send_query(32'sd4, 0, 32'sd9);
      drain_pipe();
   endtask

   // Random queries over a spread of shapes, with idle bursts on the sender while allow_idle is set.
   task automatic test_random_shapes(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         write_csr(CSR_SHAPE, $urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0: write_csr(CSR_RADIUS, $urandom);
            1: write_csr(CSR_RADIUS, $urandom_range(0, 4));
            default: write_csr(CSR_RADIUS, $urandom_range(0, 33554432));
         endcase
         write_csr(CSR_SIZE_X, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 33554432));
         write_csr(CSR_SIZE_Y, $urandom_range(0, 3) == 0 ? $urandom_range(0, 2)
                                                        : $urandom_range(0, 33554432));
         write_csr(CSR_SIZE_Z, $urandom);
         for (int i = 0; i < per_phase; i++)
            send_query(rand_coord(), rand_coord(), rand_coord());
         drain_pipe();
      end
   endtask

   initial begin
      shadow_box     = 1'b0;
      shadow_radius  = 31'd65536;
      shadow_size    = '{31'd131072, 31'd131072, 31'd131072};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values first, with no register touched.
      send_query(32'sd65536, 32'sd65536, 0);
      send_query(0, 0, 0);
      drain_pipe();

      test_sphere_corners();
      test_box_corners();
      test_random_shapes(12, 100);
      // Back-to-back tail: no idling.
      allow_idle = 1'b0;
      test_random_shapes(3, 100);

      repeat (PIPE_LATENCY) @(posedge clock);
      if (error_count == 0 && answers_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire
